// ===== hw/rtl/rgb_cmyk_converter_top_assert.svh =====
// Assertion macros shared by the color converter modules.
`ifndef RGB_CMYK_CONVERTER_TOP_ASSERT_SVH
`define RGB_CMYK_CONVERTER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clk edge out of reset.
`define RCC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clk edge out of reset.
`define RCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/rcc_pkg.sv =====
// Shared constants and pipeline word types of the color converter.
package rcc_pkg;

	localparam int unsigned CHAN_W         = 8;
	localparam int unsigned NUM_LANES      = 3;
	localparam int unsigned DIV_STAGES     = 4;
	localparam int unsigned BITS_PER_STAGE = CHAN_W / DIV_STAGES;

	typedef logic [CHAN_W-1:0] chan_t;

	localparam chan_t FULL_SCALE = chan_t'(255);

	// Direction register codes.
	localparam logic DIR_FORWARD = 1'b0;
	localparam logic DIR_REVERSE = 1'b1;

	// One lane of the long division: partial remainder, dividend bits not
	// yet consumed, and quotient bits developed so far.
	typedef struct packed {
		chan_t rem;
		chan_t low;
		chan_t quo;
	} div_lane_t;

	// Word that travels down the divider stages.
	typedef struct packed {
		div_lane_t [NUM_LANES-1:0] lane;
		chan_t                     divisor;
		chan_t                     black;
	} div_word_t;

endpackage

// ===== hw/rtl/rcc_front.sv =====
// Operand preparation and product stages of the color converter.
module rcc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              direction,
	input  rcc_pkg::chan_t    chan0,
	input  rcc_pkg::chan_t    chan1,
	input  rcc_pkg::chan_t    chan2,
	input  rcc_pkg::chan_t    chan3,
	output logic              valid_s2,
	output rcc_pkg::div_word_t word_s2
);
	import rcc_pkg::*;

	chan_t                  mx;
	chan_t [NUM_LANES-1:0]  fac_a;
	chan_t                  fac_b;
	chan_t                  div_d;
	chan_t                  black_d;

	logic                   valid_s1;
	chan_t [NUM_LANES-1:0]  fac_a_s1;
	chan_t                  fac_b_s1;
	chan_t                  div_s1;
	chan_t                  black_s1;

	// Forward mode divides (max - x) * 255 by max; reverse mode divides
	// (255 - x) * (255 - k) by 255. Pure black gets divisor one and zero
	// dividends, so its chroma comes out zero and black comes out full.
	always_comb begin
		mx = (chan0 > chan1) ? chan0 : chan1;
		mx = (mx > chan2) ? mx : chan2;
		if (direction == DIR_FORWARD) begin
			fac_a[0] = mx - chan0;
			fac_a[1] = mx - chan1;
			fac_a[2] = mx - chan2;
			fac_b    = FULL_SCALE;
			div_d    = (mx == '0) ? chan_t'(1) : mx;
			black_d  = FULL_SCALE - mx;
		end else begin
			fac_a[0] = FULL_SCALE - chan0;
			fac_a[1] = FULL_SCALE - chan1;
			fac_a[2] = FULL_SCALE - chan2;
			fac_b    = FULL_SCALE - chan3;
			div_d    = FULL_SCALE;
			black_d  = '0;
		end
	end

	// Stage one register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		fac_a_s1 <= fac_a;
		fac_b_s1 <= fac_b;
		div_s1   <= div_d;
		black_s1 <= black_d;
	end

	// Stage two: one 8 by 8 product per lane, split into the high byte that
	// seeds the remainder and the low byte that the divider shifts in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_LANES; i++) begin
			{word_s2.lane[i].rem, word_s2.lane[i].low} <= fac_a_s1[i] * fac_b_s1;
			word_s2.lane[i].quo <= '0;
		end
		word_s2.divisor <= div_s1;
		word_s2.black   <= black_s1;
	end

endmodule

// ===== hw/rtl/rcc_div_stage.sv =====
// One register stage of the restoring divider, two quotient bits per lane.
`include "rgb_cmyk_converter_top_assert.svh"

module rcc_div_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_in,
	input  rcc_pkg::div_word_t word_in,
	output logic               valid_s1,
	output rcc_pkg::div_word_t word_s1
);
	import rcc_pkg::*;

	div_word_t nxt;

	// Shift two dividend bits, one at a time, into each remainder and subtract the divisor
	// where it fits; the remainder always stays below the divisor.
	always_comb begin
		logic [CHAN_W:0] trial;
		nxt = word_in;
		for (int i = 0; i < NUM_LANES; i++) begin
			for (int j = 0; j < BITS_PER_STAGE; j++) begin
				trial = {nxt.lane[i].rem, nxt.lane[i].low[CHAN_W-1]};
				nxt.lane[i].low = {nxt.lane[i].low[CHAN_W-2:0], 1'b0};
				if (trial >= {1'b0, nxt.divisor}) begin
					trial = trial - {1'b0, nxt.divisor};
					nxt.lane[i].quo = {nxt.lane[i].quo[CHAN_W-2:0], 1'b1};
				end else begin
					nxt.lane[i].quo = {nxt.lane[i].quo[CHAN_W-2:0], 1'b0};
				end
				nxt.lane[i].rem = trial[CHAN_W-1:0];
			end
		end
	end

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		word_s1 <= nxt;
	end

	// A remainder at or above the divisor would overflow the quotient.
	`RCC_ASSERT_IMPL(a_rem_lane0, valid_in, word_in.lane[0].rem < word_in.divisor, "lane 0 remainder not below divisor")
	`RCC_ASSERT_IMPL(a_rem_lane1, valid_in, word_in.lane[1].rem < word_in.divisor, "lane 1 remainder not below divisor")
	`RCC_ASSERT_IMPL(a_rem_lane2, valid_in, word_in.lane[2].rem < word_in.divisor, "lane 2 remainder not below divisor")

endmodule

// ===== hw/rtl/rgb_cmyk_converter_top.sv =====
// Top level of the pipelined RGB / CMYK color converter.
//
//  channel   handshake          payload
//  -------   ---------------    -----------------------------------------------
//  input     start, busy        red_or_cyan, green_or_magenta, blue_or_yellow,
//                               black_in
//  result    done (strobe)      cyan_or_red, magenta_or_green, yellow_or_blue,
//                               black_out
//  config    cfg_we             cfg_wdata (direction)
//
// One word enters per cycle; busy is always low since nothing downstream stalls.
// Each word passes through operand prep, one 8x8 product, then four divider
// stages that each retire two quotient bits of a 16 by 8 restoring division.
// The result is on the outputs for one cycle with done high.
// Reset clears the direction register (forward) and all stage valid bits.
`include "rgb_cmyk_converter_top_assert.svh"

module rgb_cmyk_converter_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  rcc_pkg::chan_t red_or_cyan,
	input  rcc_pkg::chan_t green_or_magenta,
	input  rcc_pkg::chan_t blue_or_yellow,
	input  rcc_pkg::chan_t black_in,
	output logic           done,
	output rcc_pkg::chan_t cyan_or_red,
	output rcc_pkg::chan_t magenta_or_green,
	output rcc_pkg::chan_t yellow_or_blue,
	output rcc_pkg::chan_t black_out,
	input  logic           cfg_we,
	input  logic           cfg_wdata
);
	import rcc_pkg::*;

	logic      direction_q;
	logic      valid_chain [DIV_STAGES+1];
	div_word_t word_chain  [DIV_STAGES+1];

	// The pipeline never stalls, so a word is taken whenever start is high.
	assign busy = 1'b0;

	// Direction register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_FORWARD;
		end else if (cfg_we) begin
			direction_q <= cfg_wdata;
		end
	end

	// Operand prep and product stages.
	rcc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.direction (direction_q),
		.chan0     (red_or_cyan),
		.chan1     (green_or_magenta),
		.chan2     (blue_or_yellow),
		.chan3     (black_in),
		.valid_s2  (valid_chain[0]),
		.word_s2   (word_chain[0])
	);

	// Divider stages.
	for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
		rcc_div_stage u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (valid_chain[s]),
			.word_in  (word_chain[s]),
			.valid_s1 (valid_chain[s+1]),
			.word_s1  (word_chain[s+1])
		);
	end

	// Results come straight from the last stage register.
	assign done             = valid_chain[DIV_STAGES];
	assign cyan_or_red      = word_chain[DIV_STAGES].lane[0].quo;
	assign magenta_or_green = word_chain[DIV_STAGES].lane[1].quo;
	assign yellow_or_blue   = word_chain[DIV_STAGES].lane[2].quo;
	assign black_out        = word_chain[DIV_STAGES].black;

	// Every result strobe matches an earlier word taken with start high.
	`RCC_ASSERT_IMPL(a_done_latency, done, $past(start, 6), "result without a matching input word")
	// Full black carries no chroma.
	`RCC_ASSERT_IMPL(a_full_black, done && (black_out == FULL_SCALE), (cyan_or_red == '0) && (magenta_or_green == '0) && (yellow_or_blue == '0), "chroma on full black")
	// With black present one chroma channel is always zero.
	`RCC_ASSERT_IMPL(a_zero_chroma, done && (black_out != '0), (cyan_or_red == '0) || (magenta_or_green == '0) || (yellow_or_blue == '0), "no zero chroma channel")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the pipelined RGB / CMYK color converter.
module testbench;

	import rcc_pkg::*;

	// Cycles with no word accepted on either side before the run is abandoned.
	localparam int unsigned STALL_LIMIT = 2000;
	// Cycles allowed for the pipeline to settle once nothing is outstanding.
	localparam int unsigned SETTLE_CYCLES = 20;
	localparam int unsigned MAX_REPORTS = 10;

	// One converted pixel as it leaves the block.
	typedef struct packed {
		chan_t ch0;
		chan_t ch1;
		chan_t ch2;
		chan_t black;
	} pixel_out_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	logic  busy;
	chan_t red_or_cyan = '0;
	chan_t green_or_magenta = '0;
	chan_t blue_or_yellow = '0;
	chan_t black_in = '0;
	logic  done;
	chan_t cyan_or_red;
	chan_t magenta_or_green;
	chan_t yellow_or_blue;
	chan_t black_out;
	logic  cfg_we = 1'b0;
	logic  cfg_wdata = 1'b0;

	// Direction as the block should hold it, and pixels still on their way out.
	logic       model_dir = DIR_FORWARD;
	pixel_out_t pending_pixels[$];

	int unsigned mismatches = 0;
	int unsigned words_sent = 0;
	int unsigned words_checked = 0;
	int unsigned dir_writes = 0;
	int unsigned idle_cycles = 0;
	bit          no_gaps = 0;

	rgb_cmyk_converter_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.red_or_cyan      (red_or_cyan),
		.green_or_magenta (green_or_magenta),
		.blue_or_yellow   (blue_or_yellow),
		.black_in         (black_in),
		.done             (done),
		.cyan_or_red      (cyan_or_red),
		.magenta_or_green (magenta_or_green),
		.yellow_or_blue   (yellow_or_blue),
		.black_out        (black_out),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Forward scaling of one chroma channel against the common black level.
	function automatic chan_t scale_to_ink(input int unsigned ink, input int unsigned k);
		return chan_t'(((ink - k) * 255) / (255 - k));
	endfunction

	// Expected output of one pixel under the given direction.
	function automatic pixel_out_t convert_pixel(input logic dir, input chan_t x0,
			input chan_t x1, input chan_t x2, input chan_t x3);
		pixel_out_t  res;
		int unsigned ac, am, ay, k, wk;
		ac = 255 - x0;
		am = 255 - x1;
		ay = 255 - x2;
		if (dir == DIR_FORWARD) begin
			if (x0 == 0 && x1 == 0 && x2 == 0) begin
				// Pure black carries everything in the black channel.
				res = '{ch0: 8'd0, ch1: 8'd0, ch2: 8'd0, black: 8'd255};
			end else begin
				k = ac;
				if (am < k) k = am;
				if (ay < k) k = ay;
				res.ch0   = scale_to_ink(ac, k);
				res.ch1   = scale_to_ink(am, k);
				res.ch2   = scale_to_ink(ay, k);
				res.black = chan_t'(k);
			end
		end else begin
			wk = 255 - x3;
			res.ch0   = chan_t'((ac * wk) / 255);
			res.ch1   = chan_t'((am * wk) / 255);
			res.ch2   = chan_t'((ay * wk) / 255);
			res.black = '0;
		end
		return res;
	endfunction

	// Channel value that favors the ends of the range.
	function automatic chan_t pick_chan();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			2: return chan_t'($urandom_range(0, 3));
			3: return chan_t'($urandom_range(252, 255));
			default: return chan_t'($urandom);
		endcase
	endfunction

	// Value a few steps away from a base, kept inside the channel range.
	function automatic chan_t near_chan(input chan_t base);
		int v;
		v = int'(base) + int'($urandom_range(0, 8)) - 4;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return chan_t'(v);
	endfunction

	// Idle length between words: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// Offers one word and holds it until the block takes it.
	task automatic send_pixel(input chan_t x0, input chan_t x1, input chan_t x2,
			input chan_t x3);
		start            <= 1'b1;
		red_or_cyan      <= x0;
		green_or_magenta <= x1;
		blue_or_yellow   <= x2;
		black_in         <= x3;
		do @(posedge clk); while (busy);
		pending_pixels.push_back(convert_pixel(model_dir, x0, x1, x2, x3));
		words_sent++;
	endtask

	// Drops start for the given number of cycles with junk on the data lines.
	task automatic idle_for(input int unsigned cycles);
		if (cycles != 0) begin
			start            <= 1'b0;
			red_or_cyan      <= chan_t'($urandom);
			green_or_magenta <= chan_t'($urandom);
			blue_or_yellow   <= chan_t'($urandom);
			black_in         <= chan_t'($urandom);
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic send_with_gap(input chan_t x0, input chan_t x1, input chan_t x2,
			input chan_t x3);
		send_pixel(x0, x1, x2, x3);
		idle_for(pick_gap());
	endtask

	// Waits until every outstanding pixel has come back, then lets the pipe settle.
	task automatic drain_pipeline();
		idle_for(1);
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the direction register with the pipeline empty.
	task automatic set_direction(input logic dir);
		drain_pipeline();
		cfg_we    <= 1'b1;
		cfg_wdata <= dir;
		@(posedge clk);
		model_dir = dir;
		dir_writes++;
		cfg_we    <= 1'b0;
		cfg_wdata <= ~dir;
		@(posedge clk);
	endtask

	// Corner pixels in the RGB to CMYK direction.
	task automatic test_forward_corners();
		set_direction(DIR_FORWARD);
		send_with_gap(8'd0, 8'd0, 8'd0, 8'd0);
		send_with_gap(8'd0, 8'd0, 8'd0, 8'd255);
		send_with_gap(8'd255, 8'd255, 8'd255, 8'd0);
		send_with_gap(8'd255, 8'd0, 8'd0, 8'd170);
		send_with_gap(8'd0, 8'd255, 8'd0, 8'd85);
		send_with_gap(8'd0, 8'd0, 8'd255, 8'd255);
		send_with_gap(8'd1, 8'd0, 8'd0, 8'd0);
		send_with_gap(8'd0, 8'd0, 8'd1, 8'd0);
		send_with_gap(8'd254, 8'd254, 8'd254, 8'd0);
		send_with_gap(8'd1, 8'd1, 8'd1, 8'd0);
		send_with_gap(8'd254, 8'd255, 8'd253, 8'd0);
		send_with_gap(8'd128, 8'd64, 8'd32, 8'd0);
	endtask

	// Corner pixels in the CMYK to RGB direction; black out must stay zero.
	task automatic test_reverse_corners();
		set_direction(DIR_REVERSE);
		send_with_gap(8'd0, 8'd0, 8'd0, 8'd0);
		send_with_gap(8'd255, 8'd255, 8'd255, 8'd255);
		send_with_gap(8'd0, 8'd0, 8'd0, 8'd255);
		send_with_gap(8'd255, 8'd255, 8'd255, 8'd0);
		send_with_gap(8'd255, 8'd0, 8'd0, 8'd0);
		send_with_gap(8'd0, 8'd255, 8'd0, 8'd1);
		send_with_gap(8'd0, 8'd0, 8'd255, 8'd254);
		send_with_gap(8'd1, 8'd1, 8'd1, 8'd1);
		send_with_gap(8'd254, 8'd254, 8'd254, 8'd254);
		send_with_gap(8'd128, 8'd64, 8'd32, 8'd16);
	endtask

	// Random RGB words, many of them nearly gray so black takes most of the range.
	task automatic test_forward_random(input int unsigned count);
		chan_t base;
		set_direction(DIR_FORWARD);
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 2) == 0) begin
				base = pick_chan();
				send_with_gap(near_chan(base), near_chan(base), near_chan(base),
					chan_t'($urandom));
			end else begin
				send_with_gap(pick_chan(), pick_chan(), pick_chan(), chan_t'($urandom));
			end
			// Hold off once until everything sent so far is back.
			if (i == count / 2) drain_pipeline();
		end
		no_gaps = 0;
	endtask

	// Random CMYK words.
	task automatic test_reverse_random(input int unsigned count);
		set_direction(DIR_REVERSE);
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			send_with_gap(pick_chan(), pick_chan(), pick_chan(), pick_chan());
		end
		no_gaps = 0;
	endtask

	// Short runs in alternating and repeated directions.
	task automatic test_direction_switching(input int unsigned phases);
		logic dir;
		for (int unsigned p = 0; p < phases; p++) begin
			dir = ($urandom_range(0, 2) == 0) ? model_dir : ~model_dir;
			set_direction(dir);
			repeat ($urandom_range(10, 40))
				send_with_gap(pick_chan(), pick_chan(), pick_chan(), pick_chan());
		end
	endtask

	// Result checker: every strobed pixel against the oldest expectation.
	always @(posedge clk) begin
		pixel_out_t got;
		pixel_out_t want;
		if (arst_n && done) begin
			got = '{ch0: cyan_or_red, ch1: magenta_or_green, ch2: yellow_or_blue,
				black: black_out};
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("Unexpected result word %h %h %h %h", got.ch0, got.ch1,
						got.ch2, got.black);
			end else begin
				want = pending_pixels.pop_front();
				words_checked++;
				if (got.ch0 !== want.ch0 || got.ch1 !== want.ch1 ||
						got.ch2 !== want.ch2 || got.black !== want.black) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("Mismatch on word %0d: expected %h %h %h %h, got %h %h %h %h",
							words_checked, want.ch0, want.ch1, want.ch2, want.black,
							got.ch0, got.ch1, got.ch2, got.black);
				end
			end
		end
	end

	// Watchdog on cycles in which no word moves in either direction.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout with %0d results outstanding", pending_pixels.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset value of the direction register is forward.
		send_with_gap(8'd10, 8'd200, 8'd90, 8'd0);

		test_forward_corners();
		test_reverse_corners();
		test_forward_random(250);
		test_reverse_random(230);
		test_direction_switching(8);
		drain_pipeline();

		if (pending_pixels.size() != 0) mismatches++;
		$display("Sent %0d words and checked %0d results across %0d direction writes.",
			words_sent, words_checked, dir_writes);
		$display("Covered corner and random pixels in both directions with random idling.");
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
